### sv/mcm_pkg.sv
// Package for the MIDI control-change mapper: payload structs, table entry
// layout, kind and output codes, register indexes and MIDI byte constants.
// No dependencies.
package mcm_pkg;

   localparam int KIND_W      = 3;
   localparam int CHAN_W      = 7;
   localparam int LEVEL_W     = 8;
   localparam int CTRL_W      = 7;
   localparam int VALUE_W     = 7;
   localparam int SCALE_W     = 8;
   localparam int LISTEN_W    = 6;
   localparam int PROD_W      = VALUE_W + SCALE_W;
   localparam int CSR_ADDR_W  = 2;
   localparam int CSR_DATA_W  = 8;
   localparam int TABLE_DEPTH = 128;
   localparam int ENTRY_W     = KIND_W + CHAN_W + 1;

   // quotient estimate is product >> 7; the true quotient lies at most
   // MAX_CORR above it for both divisors
   localparam int DIV_SHIFT = 7;
   localparam int MAX_CORR  = 4;
   localparam int DIV_FADER = 127;
   localparam int DIV_PAN   = 126;

   localparam logic ACTION_MESSAGE = 1'b0;
   localparam logic ACTION_WRITE   = 1'b1;

   // table entry kinds
   localparam logic [KIND_W-1:0] ENTRY_NONE      = 3'd0;
   localparam logic [KIND_W-1:0] ENTRY_FADER     = 3'd1;
   localparam logic [KIND_W-1:0] ENTRY_PAN       = 3'd2;
   localparam logic [KIND_W-1:0] ENTRY_SOLO      = 3'd3;
   localparam logic [KIND_W-1:0] ENTRY_MUTE      = 3'd4;
   localparam logic [KIND_W-1:0] ENTRY_MUTE_SELF = 3'd5;

   // result control kinds
   localparam logic [KIND_W-1:0] CTRL_FADER     = 3'd0;
   localparam logic [KIND_W-1:0] CTRL_PAN       = 3'd1;
   localparam logic [KIND_W-1:0] CTRL_SOLO      = 3'd2;
   localparam logic [KIND_W-1:0] CTRL_MUTE      = 3'd3;
   localparam logic [KIND_W-1:0] CTRL_MUTE_SELF = 3'd4;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_LISTEN = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_FADER  = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_PAN    = 2'd2;

   // MIDI bytes
   localparam logic [7:0] STATUS_VOICE_LO = 8'h80;
   localparam logic [7:0] STATUS_SYSTEM   = 8'hF0;
   localparam logic [7:0] STATUS_CC       = 8'hB0;
   localparam logic [7:0] STATUS_CC_END   = 8'hC0;
   localparam logic [7:0] DATA_MAX        = 8'd127;
   localparam logic [7:0] FLAG_ON         = 8'h40;
   localparam logic [1:0] FULL_PACKET     = 2'd3;

   typedef struct packed {
      logic                action;
      logic [1:0]          byte_count;
      logic [7:0]          status_byte;
      logic [7:0]          data_one;
      logic [7:0]          data_two;
      logic [CTRL_W-1:0]   entry_index;
      logic [KIND_W-1:0]   entry_kind;
      logic [CHAN_W-1:0]   entry_channel;
      logic                entry_own_flag;
   } req_type;

   typedef struct packed {
      logic [KIND_W-1:0]   control_kind;
      logic [CHAN_W-1:0]   mixer_channel;
      logic                own_channel;
      logic [LEVEL_W-1:0]  level;
   } rsp_type;

   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [CHAN_W-1:0]   chan;
      logic                own;
   } entry_type;

   typedef struct packed {
      logic [PROD_W-1:0]   product;
      logic                is_pan;
   } scale_req_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_SCALE
   } state_type;

endpackage

### sv/mcm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mcm_ram #(
   parameter int WIDTH = 11,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/mcm_scaler.sv
// Exact floor division of a registered product by 127 (fader) or 126 (pan).
// Depends on mcm_pkg.
module mcm_scaler (
   input  mcm_pkg::scale_req_type           scale_req,
   output logic [mcm_pkg::LEVEL_W-1:0]      level
);
   import mcm_pkg::*;

   logic [LEVEL_W-1:0] q_est;
   logic [PROD_W-1:0]  base;
   logic [PROD_W-1:0]  rem;
   logic [2:0]         inc;

   // product/128 undershoots product/127 by < 2 and product/126 by < 4
   assign q_est = scale_req.product[PROD_W-1:DIV_SHIFT];
   assign base  = scale_req.is_pan
                ? (PROD_W'(q_est) << DIV_SHIFT) - (PROD_W'(q_est) << 1)
                : (PROD_W'(q_est) << DIV_SHIFT) - PROD_W'(q_est);
   assign rem   = scale_req.product - base;

   always_comb begin
      inc = '0;
      for (int k = 1; k <= MAX_CORR; k++) begin
         if (rem >= (scale_req.is_pan ? PROD_W'(k * DIV_PAN) : PROD_W'(k * DIV_FADER))) begin
            inc = 3'(k);
         end
      end
   end

   assign level = q_est + LEVEL_W'(inc);

endmodule

### sv/midi_cc_to_mixer_control_mapper_top.sv
// Top level of the MIDI control-change to mixer control mapper.
// Depends on mcm_pkg, mcm_ram and mcm_scaler.
//
//   channel  ports                          direction  transaction
//   req      req_valid/req_stall/req_data   in         message or table write
//   rsp      rsp_valid/rsp_stall/rsp_data   out        one mixer control result
//   csr      csr_we/csr_addr/csr_wdata      in         register write, no wait
//
// A table write is taken in the idle state; while idle, writes can follow each other every cycle.
// A message that passes the header checks and hits a mapped entry goes through
// accept, table read through the RAM and scaling from the registered product,
// and req stalls until it is done; one that hits an unmapped entry ends after
// the table read, and a dropped message is discarded at accept.
// Reset clears the 128 per-entry valid bits directly: no clearing pass.
// A result waits in the output register; a new item is taken meanwhile, and
// only the final scaling step holds (req stalls behind it) while that register is full and stalled.
module midi_cc_to_mixer_control_mapper_top #(
   parameter int MAX_CHANNELS = 128
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  mcm_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output mcm_pkg::rsp_type                   rsp_data,
   input  logic                               csr_we,
   input  logic [mcm_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [mcm_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import mcm_pkg::*;

   localparam int ADDR_W = $clog2(TABLE_DEPTH);

   // configuration
   logic [LISTEN_W-1:0] listen_ff;
   logic [SCALE_W-1:0]  fader_fs_ff;
   logic [SCALE_W-1:0]  pan_fs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         listen_ff   <= LISTEN_W'(-1);
         fader_fs_ff <= SCALE_W'(100);
         pan_fs_ff   <= SCALE_W'(100);
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_LISTEN: listen_ff   <= csr_wdata[LISTEN_W-1:0];
            CSR_FADER:  fader_fs_ff <= csr_wdata;
            CSR_PAN:    pan_fs_ff   <= csr_wdata;
            default:    ;
         endcase
      end
   end

   // state machine
   state_type state_ff, state_in;

   logic req_accept;
   logic msg_ok;
   logic chan_ok;
   logic write_ok;
   logic ram_we;
   logic lookup_en;
   logic rsp_load;
   logic load_ok;
   logic has_result;
   logic rsp_valid_ff;

   assign req_accept = req_valid && !req_stall;
   assign load_ok    = !rsp_valid_ff || !rsp_stall;

   // channel match: negative listens to nothing, zero to all
   logic [4:0] listen_m1;
   assign listen_m1 = listen_ff[4:0] - 5'd1;
   assign chan_ok   = !listen_ff[LISTEN_W-1]
                   && ((listen_ff == '0) || (listen_m1 == {1'b0, req_data.status_byte[3:0]}));

   assign msg_ok = (req_data.action == ACTION_MESSAGE)
                && (req_data.byte_count != '0)
                && (req_data.status_byte >= STATUS_VOICE_LO)
                && (req_data.status_byte <  STATUS_SYSTEM)
                && chan_ok
                && (req_data.status_byte >= STATUS_CC)
                && (req_data.status_byte <  STATUS_CC_END)
                && (req_data.byte_count == FULL_PACKET)
                && (req_data.data_one <= DATA_MAX)
                && (req_data.data_two <= DATA_MAX);

   // out-of-range channel writes are dropped unless the own flag is set
   assign write_ok = (req_data.action == ACTION_WRITE)
                  && (req_data.entry_own_flag
                      || ({1'b0, req_data.entry_channel} < 8'(MAX_CHANNELS)));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_valid && msg_ok) state_in = ST_LOOKUP;
         ST_LOOKUP: state_in = has_result ? ST_SCALE : ST_IDLE;
         ST_SCALE:  if (load_ok) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall = (state_ff != ST_IDLE);
      ram_we    = (state_ff == ST_IDLE) && req_valid && write_ok;
      lookup_en = (state_ff == ST_LOOKUP);
      rsp_load  = (state_ff == ST_SCALE) && load_ok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // mapping table: RAM plus one valid bit per entry; an unwritten entry
   // reads as kind none
   entry_type           wr_entry;
   logic [ENTRY_W-1:0]  ram_rdata;
   logic [TABLE_DEPTH-1:0] valid_ff;
   logic                valid_rd_ff;
   logic [ADDR_W-1:0]   rd_addr;

   assign rd_addr       = req_data.data_one[ADDR_W-1:0];
   assign wr_entry.kind = req_data.entry_kind;
   assign wr_entry.chan = req_data.entry_own_flag ? '0 : req_data.entry_channel;
   assign wr_entry.own  = req_data.entry_own_flag;

   mcm_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (req_data.entry_index[ADDR_W-1:0]),
      .wr_data (wr_entry),
      .rd_addr (rd_addr),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (ram_we) begin
         valid_ff[req_data.entry_index[ADDR_W-1:0]] <= 1'b1;
      end
   end

   // sampled with the RAM read so both describe the same entry
   always_ff @(posedge clock) begin
      valid_rd_ff <= valid_ff[rd_addr];
   end

   // controller value, held from the accepted message
   logic [VALUE_W-1:0] value_ff;
   always_ff @(posedge clock) begin
      if (req_accept) begin
         value_ff <= req_data.data_two[VALUE_W-1:0];
      end
   end

   // lookup: decode the entry, register the product for scaling
   entry_type          entry;
   logic [KIND_W-1:0]  kind_c;
   logic [CHAN_W-1:0]  chan_c;
   logic               own_c;
   logic               is_pan_c;
   logic               scaled_c;
   logic [VALUE_W-1:0] mult_c;
   logic [SCALE_W-1:0] fs_c;
   logic               flag_c;

   assign entry  = valid_rd_ff ? entry_type'(ram_rdata) : '0;
   assign flag_c = ({1'b0, value_ff} >= FLAG_ON);

   always_comb begin
      has_result = 1'b1;
      kind_c     = CTRL_FADER;
      chan_c     = entry.chan;
      own_c      = entry.own;
      is_pan_c   = 1'b0;
      scaled_c   = 1'b0;
      mult_c     = value_ff;
      fs_c       = fader_fs_ff;
      unique case (entry.kind)
         ENTRY_FADER: begin
            scaled_c = 1'b1;
         end
         ENTRY_PAN: begin
            kind_c   = CTRL_PAN;
            is_pan_c = 1'b1;
            scaled_c = 1'b1;
            mult_c   = (value_ff == '0) ? '0 : value_ff - VALUE_W'(1);
            fs_c     = pan_fs_ff;
         end
         ENTRY_SOLO: kind_c = CTRL_SOLO;
         ENTRY_MUTE: kind_c = CTRL_MUTE;
         ENTRY_MUTE_SELF: begin
            kind_c = CTRL_MUTE_SELF;
            chan_c = '0;
            own_c  = 1'b0;
         end
         default: has_result = 1'b0;   // none and unused codes
      endcase
   end

   scale_req_type      scale_ff;
   logic               scaled_ff;
   logic               flag_ff;
   logic [KIND_W-1:0]  kind_ff;
   logic [CHAN_W-1:0]  chan_ff;
   logic               own_ff;

   always_ff @(posedge clock) begin
      if (lookup_en) begin
         scale_ff.product <= PROD_W'(mult_c) * PROD_W'(fs_c);
         scale_ff.is_pan  <= is_pan_c;
         scaled_ff        <= scaled_c;
         flag_ff          <= flag_c;
         kind_ff          <= kind_c;
         chan_ff          <= chan_c;
         own_ff           <= own_c;
      end
   end

   logic [LEVEL_W-1:0] scaled_level;

   mcm_scaler u_scaler (
      .scale_req (scale_ff),
      .level     (scaled_level)
   );

   // output register
   rsp_type rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff.control_kind  <= kind_ff;
         rsp_data_ff.mixer_channel <= chan_ff;
         rsp_data_ff.own_channel   <= own_ff;
         rsp_data_ff.level         <= scaled_ff ? scaled_level : LEVEL_W'(flag_ff);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // checks
   a_rsp_from_scale: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_SCALE)
      else $error("result appeared without a scaling step");

   a_write_no_result: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_data.action == ACTION_WRITE) |=> state_ff == ST_IDLE)
      else $error("table write started a lookup");

   a_scale_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCALE && rsp_valid_ff && rsp_stall) |=> state_ff == ST_SCALE)
      else $error("scaled result dropped while output stalled");

   a_reset_clears_table: assert property (@(posedge clock)
      reset |=> valid_ff == '0)
      else $error("table valid bits not cleared by reset");

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench for midi_cc_to_mixer_control_mapper_top.
// Needs mcm_pkg and the mapper RTL; drives the req and csr ports, checks rsp
// transactions against an in-bench model of the mapping table and scaling.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import mcm_pkg::*;

   localparam int      MAX_CHANNELS  = 128;
   localparam int      CLK_PERIOD    = 20;
   localparam int      RESET_CYCLES  = 5;
   // a message passes accept, table read and scaling inside the block; a dropped message or a
   // table write leaves nothing in the result queue, so settle a bit longer
   localparam int      SETTLE_CYCLES = 10;
   localparam int      HOLD_CYCLES   = 200;
   localparam int      N_PHASES      = 8;
   localparam int      PRESSURE_PH   = 4;
   localparam int      PHASE_ITEMS   = 78;
   localparam longint  WATCHDOG_NS   = 5_000_000;

   // listen_channel codes and the two kind codes the block treats as unmapped
   localparam logic [LISTEN_W-1:0] LISTEN_ALL  = 6'd0;
   localparam logic [LISTEN_W-1:0] LISTEN_NONE = 6'h3F;
   localparam logic [KIND_W-1:0]   ENTRY_UNUSED_6 = 3'd6;
   localparam logic [KIND_W-1:0]   ENTRY_UNUSED_7 = 3'd7;

   typedef enum logic [1:0] {CHK_PREDICT, CHK_NONE, CHK_RESULT} check_mode_type;
   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   // one line of the directed stimulus: a transaction or a register write
   typedef struct {
      row_kind_type             kind;
      req_type                  item;
      check_mode_type           chk;
      rsp_type                  want;
      logic [CSR_ADDR_W-1:0]    addr;
      logic [CSR_DATA_W-1:0]    data;
   } dir_row_type;

   logic                    clock     = 1'b0;
   logic                    reset     = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   req_type                 req_data  = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   rsp_type                 rsp_data;
   logic                    csr_we    = 1'b0;
   logic [CSR_ADDR_W-1:0]   csr_addr  = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;

   // bench copy of the block state
   entry_type               mix_table [TABLE_DEPTH];
   logic [LISTEN_W-1:0]     cfg_listen;
   logic [SCALE_W-1:0]      cfg_fader;
   logic [SCALE_W-1:0]      cfg_pan;

   rsp_type                 pending_controls [$];
   dir_row_type             dir_rows [$];

   int                      sender_idle_pct    = 0;
   int                      receiver_stall_pct = 0;
   int                      hold_ask           = 0;
   int                      hold_taken         = 0;
   int                      hold_left          = 0;

   int                      items_sent       = 0;
   int                      writes_sent      = 0;
   int                      live_items       = 0;
   int                      controls_checked = 0;
   int                      settings_written = 0;
   int                      errors           = 0;

   always #(CLK_PERIOD / 2) clock = ~clock;

   midi_cc_to_mixer_control_mapper_top #(
      .MAX_CHANNELS (MAX_CHANNELS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   // Expected mixer control for one accepted transaction. Table writes update
   // the bench table and never give a result; messages run the header checks
   // in the block's order and then look up the controller.
   function automatic bit mixer_control_for(input req_type it, output rsp_type r);
      entry_type   e;
      int unsigned val;
      int unsigned lv;
      r = '0;
      if (it.action == ACTION_WRITE) begin
         e.kind = it.entry_kind;
         e.own  = it.entry_own_flag;
         e.chan = it.entry_own_flag ? '0 : it.entry_channel;
         // a channel beyond the mixer size leaves the entry alone
         if (it.entry_own_flag || int'(it.entry_channel) < MAX_CHANNELS) begin
            mix_table[it.entry_index] = e;
         end
         return 1'b0;
      end
      if (it.byte_count == 2'd0) return 1'b0;
      if (it.status_byte < STATUS_VOICE_LO || it.status_byte >= STATUS_SYSTEM) return 1'b0;
      // sign bit set: nothing matches; zero: every channel matches
      if (cfg_listen[LISTEN_W-1]) return 1'b0;
      if (cfg_listen != LISTEN_ALL &&
          int'(cfg_listen) - 1 != int'(it.status_byte[3:0])) return 1'b0;
      if (it.status_byte < STATUS_CC || it.status_byte >= STATUS_CC_END) return 1'b0;
      if (it.byte_count < FULL_PACKET) return 1'b0;
      if (it.data_one > DATA_MAX || it.data_two > DATA_MAX) return 1'b0;

      e   = mix_table[it.data_one[CTRL_W-1:0]];
      val = 32'(it.data_two);
      r.mixer_channel = e.chan;
      r.own_channel   = e.own;
      case (e.kind)
         ENTRY_FADER: begin
            lv = (val * cfg_fader) / DIV_FADER;
            r.control_kind = CTRL_FADER;
            r.level        = LEVEL_W'(lv);
         end
         ENTRY_PAN: begin
            lv = ((val == 0) ? 0 : val - 1) * cfg_pan / DIV_PAN;
            r.control_kind = CTRL_PAN;
            r.level        = LEVEL_W'(lv);
         end
         ENTRY_SOLO: begin
            r.control_kind = CTRL_SOLO;
            r.level        = (val >= FLAG_ON) ? 8'd1 : 8'd0;
         end
         ENTRY_MUTE: begin
            r.control_kind = CTRL_MUTE;
            r.level        = (val >= FLAG_ON) ? 8'd1 : 8'd0;
         end
         ENTRY_MUTE_SELF: begin
            // mute-myself carries no target channel
            r.control_kind  = CTRL_MUTE_SELF;
            r.mixer_channel = '0;
            r.own_channel   = 1'b0;
            r.level         = (val >= FLAG_ON) ? 8'd1 : 8'd0;
         end
         default: return 1'b0;
      endcase
      return 1'b1;
   endfunction

   // directed table rows
   function automatic dir_row_type row_write(int idx, logic [KIND_W-1:0] kind, int chan,
                                             bit own);
      dir_row_type r;
      r.kind = ROW_ITEM;
      r.item = '0;
      r.item.action         = ACTION_WRITE;
      r.item.entry_index    = CTRL_W'(idx);
      r.item.entry_kind     = kind;
      r.item.entry_channel  = CHAN_W'(chan);
      r.item.entry_own_flag = own;
      r.chk  = CHK_NONE;
      r.want = '0;
      r.addr = '0;
      r.data = '0;
      return r;
   endfunction

   function automatic dir_row_type row_msg(logic [1:0] cnt, logic [7:0] st, logic [7:0] d1,
                                           logic [7:0] d2, check_mode_type chk,
                                           rsp_type want);
      dir_row_type r;
      r.kind = ROW_ITEM;
      r.item = '0;
      r.item.action      = ACTION_MESSAGE;
      r.item.byte_count  = cnt;
      r.item.status_byte = st;
      r.item.data_one    = d1;
      r.item.data_two    = d2;
      r.chk  = chk;
      r.want = want;
      r.addr = '0;
      r.data = '0;
      return r;
   endfunction

   function automatic dir_row_type row_csr(logic [CSR_ADDR_W-1:0] addr,
                                           logic [CSR_DATA_W-1:0] data);
      dir_row_type r;
      r.kind = ROW_CSR;
      r.item = '0;
      r.chk  = CHK_NONE;
      r.want = '0;
      r.addr = addr;
      r.data = data;
      return r;
   endfunction

   // Random transaction: a quarter table writes, most of the rest clean
   // control-change messages aimed at a small set of controllers, then
   // messages with one defect, then raw noise.
   function automatic req_type random_item();
      req_type     it;
      int unsigned pick;
      logic [3:0]  nib;
      it.action         = 1'($urandom);
      it.byte_count     = 2'($urandom);
      it.status_byte    = 8'($urandom);
      it.data_one       = 8'($urandom);
      it.data_two       = 8'($urandom);
      it.entry_index    = CTRL_W'($urandom);
      it.entry_kind     = KIND_W'($urandom);
      it.entry_channel  = CHAN_W'($urandom);
      it.entry_own_flag = 1'($urandom);
      pick = $urandom_range(99);
      if (pick < 25) begin
         it.action      = ACTION_WRITE;
         it.entry_index = ($urandom_range(9) != 0) ? CTRL_W'($urandom_range(15)) : it.entry_index;
         if ($urandom_range(6) != 0) begin
            it.entry_kind = KIND_W'($urandom_range(ENTRY_MUTE_SELF, ENTRY_FADER));
         end
         it.entry_own_flag = ($urandom_range(3) == 0);
      end else if (pick < 90) begin
         nib = 4'($urandom);
         if (!cfg_listen[LISTEN_W-1] && cfg_listen != LISTEN_ALL && cfg_listen <= 6'd16 &&
             $urandom_range(6) != 0) begin
            nib = 4'(cfg_listen - 6'd1);
         end
         it.action      = ACTION_MESSAGE;
         it.byte_count  = FULL_PACKET;
         it.status_byte = STATUS_CC | {4'h0, nib};
         it.data_one    = ($urandom_range(9) != 0) ? 8'($urandom_range(15)) :
                                                     8'($urandom_range(127));
         case ($urandom_range(9))
            0:       it.data_two = 8'd0;
            1:       it.data_two = 8'd1;
            2:       it.data_two = FLAG_ON - 8'd1;
            3:       it.data_two = FLAG_ON;
            4:       it.data_two = DATA_MAX;
            default: it.data_two = 8'($urandom_range(127));
         endcase
         // one defect in a message that would otherwise pass
         if (pick >= 80) begin
            case ($urandom_range(3))
               0:       it.byte_count  = 2'($urandom_range(2));
               1:       it.status_byte = {4'($urandom_range(14, 8)) ^ 4'h3, nib};
               2:       it.data_one    = it.data_one | 8'h80;
               default: it.data_two    = it.data_two | 8'h80;
            endcase
         end
      end
      return it;
   endfunction

   // Offer one transaction, hold it until taken, then record what it should
   // produce. live is set when the transaction is a table write or gives a result.
   task automatic send_item(input req_type it, input check_mode_type chk, input rsp_type want,
                            output bit live);
      rsp_type predicted;
      bit      has_result;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      has_result = mixer_control_for(it, predicted);
      case (chk)
         CHK_PREDICT: begin
            if (has_result) pending_controls.push_back(predicted);
         end
         CHK_RESULT: begin
            pending_controls.push_back(want);
         end
         default: ;
      endcase
      live = has_result || (it.action == ACTION_WRITE);
      items_sent++;
      if (it.action == ACTION_WRITE) writes_sent++;
   endtask

   // Drop valid, wait for every expected result, then let the pipe empty.
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_controls.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register write; lowers the enable again so back-to-back calls never
   // schedule two values on csr_we in one step.
   task automatic cfg_write(input logic [CSR_ADDR_W-1:0] addr, input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (addr)
         CSR_LISTEN: cfg_listen = data[LISTEN_W-1:0];
         CSR_FADER:  cfg_fader  = data;
         CSR_PAN:    cfg_pan    = data;
         default: ;
      endcase
      settings_written++;
   endtask

   // Receiver: random stall at the phase's rate, or a long hold-off counted
   // here once the stimulus asks for one (hold_ask bumped).
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else if (hold_ask != hold_taken) begin
         hold_taken = hold_ask;
         hold_left  = HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
      end
   end

   // Result checker: each taken rsp transaction against the oldest expectation.
   always @(posedge clock) begin
      rsp_type exp_ctl;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_controls.size() == 0) begin
            $error("unexpected result: kind %0d channel %0d own %0d level %0d",
                   rsp_data.control_kind, rsp_data.mixer_channel,
                   rsp_data.own_channel, rsp_data.level);
            errors++;
         end else begin
            exp_ctl = pending_controls.pop_front();
            controls_checked++;
            if (rsp_data.control_kind !== exp_ctl.control_kind) begin
               $error("control_kind: expected %0d, got %0d",
                      exp_ctl.control_kind, rsp_data.control_kind);
               errors++;
            end
            if (rsp_data.mixer_channel !== exp_ctl.mixer_channel) begin
               $error("mixer_channel: expected %0d, got %0d",
                      exp_ctl.mixer_channel, rsp_data.mixer_channel);
               errors++;
            end
            if (rsp_data.own_channel !== exp_ctl.own_channel) begin
               $error("own_channel: expected %0d, got %0d",
                      exp_ctl.own_channel, rsp_data.own_channel);
               errors++;
            end
            if (rsp_data.level !== exp_ctl.level) begin
               $error("level: expected %0d, got %0d", exp_ctl.level, rsp_data.level);
               errors++;
            end
         end
      end
   end

   // Watchdog: a hung handshake or a missing result ends up here.
   initial begin
      #(WATCHDOG_NS);
      $display("tb_top: done, errors");
      $finish;
   end

   initial begin
      int                    ph;
      bit                    live;
      logic [LISTEN_W-1:0]   lis;
      logic [SCALE_W-1:0]    fs;
      logic [SCALE_W-1:0]    ps;
      int unsigned           r;

      foreach (mix_table[i]) mix_table[i] = '0;
      cfg_listen = LISTEN_NONE;
      cfg_fader  = 8'd100;
      cfg_pan    = 8'd100;

      // Directed part. Reset values first: listen none, both scales 100.
      dir_rows.push_back(row_write(0,   ENTRY_FADER,     127, 1'b0));
      dir_rows.push_back(row_write(127, ENTRY_PAN,       5,   1'b0));
      dir_rows.push_back(row_write(1,   ENTRY_SOLO,      127, 1'b1)); // own: channel stored as 0
      dir_rows.push_back(row_write(2,   ENTRY_MUTE,      64,  1'b0));
      dir_rows.push_back(row_write(3,   ENTRY_MUTE_SELF, 99,  1'b1));
      dir_rows.push_back(row_write(4,   ENTRY_UNUSED_7,  1,   1'b0));
      dir_rows.push_back(row_write(5,   ENTRY_UNUSED_6,  2,   1'b0));
      // listening to nothing after reset
      dir_rows.push_back(row_msg(FULL_PACKET, 8'hBF, 8'd0, 8'd127, CHK_NONE, '0));
      dir_rows.push_back(row_csr(CSR_LISTEN, {2'b00, LISTEN_ALL}));
      dir_rows.push_back(row_msg(FULL_PACKET, STATUS_CC, 8'd0, 8'd127, CHK_RESULT,
                                 rsp_type'{CTRL_FADER, 7'd127, 1'b0, 8'd100}));
      dir_rows.push_back(row_msg(FULL_PACKET, 8'hBF, 8'd127, 8'd127, CHK_RESULT,
                                 rsp_type'{CTRL_PAN, 7'd5, 1'b0, 8'd100}));
      dir_rows.push_back(row_msg(FULL_PACKET, 8'hBF, 8'd127, 8'd0, CHK_RESULT,
                                 rsp_type'{CTRL_PAN, 7'd5, 1'b0, 8'd0}));
      dir_rows.push_back(row_msg(FULL_PACKET, 8'hB3, 8'd1, FLAG_ON, CHK_RESULT,
                                 rsp_type'{CTRL_SOLO, 7'd0, 1'b1, 8'd1}));
      dir_rows.push_back(row_msg(FULL_PACKET, STATUS_CC, 8'd2, FLAG_ON - 8'd1, CHK_RESULT,
                                 rsp_type'{CTRL_MUTE, 7'd64, 1'b0, 8'd0}));
      dir_rows.push_back(row_msg(FULL_PACKET, STATUS_CC, 8'd3, 8'd127, CHK_RESULT,
                                 rsp_type'{CTRL_MUTE_SELF, 7'd0, 1'b0, 8'd1}));
      // unused kind codes and an entry never written
      dir_rows.push_back(row_msg(FULL_PACKET, STATUS_CC, 8'd4, 8'd127, CHK_NONE, '0));
      dir_rows.push_back(row_msg(FULL_PACKET, STATUS_CC, 8'd5, 8'd127, CHK_NONE, '0));
      dir_rows.push_back(row_msg(FULL_PACKET, STATUS_CC, 8'd6, 8'd127, CHK_NONE, '0));
      // header drops: length, status outside channel voice, non-CC, data bytes
      dir_rows.push_back(row_msg(2'd0, STATUS_CC, 8'd0, 8'd127, CHK_NONE, '0));
      dir_rows.push_back(row_msg(2'd2, STATUS_CC, 8'd0, 8'd127, CHK_NONE, '0));
      dir_rows.push_back(row_msg(FULL_PACKET, 8'h7F, 8'd0, 8'd127, CHK_NONE, '0));
      dir_rows.push_back(row_msg(FULL_PACKET, STATUS_SYSTEM, 8'd0, 8'd127, CHK_NONE, '0));
      dir_rows.push_back(row_msg(FULL_PACKET, 8'h9F, 8'd0, 8'd127, CHK_NONE, '0));
      dir_rows.push_back(row_msg(FULL_PACKET, STATUS_CC, 8'd255, 8'd127, CHK_NONE, '0));
      dir_rows.push_back(row_msg(FULL_PACKET, STATUS_CC, 8'd0, 8'd255, CHK_NONE, '0));
      // single channel 16 (nibble 15)
      dir_rows.push_back(row_csr(CSR_LISTEN, 8'd16));
      dir_rows.push_back(row_msg(FULL_PACKET, 8'hBF, 8'd0, FLAG_ON, CHK_PREDICT, '0));
      dir_rows.push_back(row_msg(FULL_PACKET, 8'hBE, 8'd0, FLAG_ON, CHK_NONE, '0));
      // zero full scale
      dir_rows.push_back(row_csr(CSR_FADER, 8'd0));
      dir_rows.push_back(row_csr(CSR_PAN,   8'd0));
      dir_rows.push_back(row_msg(FULL_PACKET, 8'hBF, 8'd0, 8'd127, CHK_RESULT,
                                 rsp_type'{CTRL_FADER, 7'd127, 1'b0, 8'd0}));
      dir_rows.push_back(row_msg(FULL_PACKET, 8'hBF, 8'd127, 8'd127, CHK_RESULT,
                                 rsp_type'{CTRL_PAN, 7'd5, 1'b0, 8'd0}));
      // top of both scales
      dir_rows.push_back(row_csr(CSR_FADER, 8'd255));
      dir_rows.push_back(row_csr(CSR_PAN,   8'd255));
      dir_rows.push_back(row_msg(FULL_PACKET, 8'hBF, 8'd0, 8'd127, CHK_RESULT,
                                 rsp_type'{CTRL_FADER, 7'd127, 1'b0, 8'd255}));
      dir_rows.push_back(row_msg(FULL_PACKET, 8'hBF, 8'd127, 8'd127, CHK_RESULT,
                                 rsp_type'{CTRL_PAN, 7'd5, 1'b0, 8'd255}));

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         if (dir_rows[i].kind == ROW_CSR) begin
            settle();
            cfg_write(dir_rows[i].addr, dir_rows[i].data);
         end else begin
            send_item(dir_rows[i].item, dir_rows[i].chk, dir_rows[i].want, live);
         end
      end

      // Random part: phases cycle through idling mixes, each with its own
      // register setting; the first three pin the extremes.
      for (ph = 0; ph < N_PHASES; ph++) begin
         settle();
         case (ph)
            0: begin
               lis = LISTEN_ALL;
               fs  = 8'd255;
               ps  = 8'd255;
            end
            1: begin
               lis = 6'd16;
               fs  = 8'd1;
               ps  = 8'd1;
            end
            2: begin
               lis = 6'd1;
               fs  = 8'd0;
               ps  = 8'd255;
            end
            default: begin
               r = $urandom_range(99);
               if (r < 35)      lis = LISTEN_ALL;
               else if (r < 85) lis = LISTEN_W'($urandom_range(16, 1));
               else             lis = LISTEN_W'($urandom);
               fs = ($urandom_range(3) == 0) ? ($urandom_range(1) ? 8'd255 : 8'd1) :
                                               8'($urandom_range(255, 1));
               ps = ($urandom_range(3) == 0) ? ($urandom_range(1) ? 8'd255 : 8'd1) :
                                               8'($urandom_range(255, 1));
            end
         endcase
         cfg_write(CSR_LISTEN, {2'b00, lis});
         cfg_write(CSR_FADER, fs);
         cfg_write(CSR_PAN, ps);

         case (ph % 4)
            0: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 0;
            end
            1: begin
               sender_idle_pct    = 63;
               receiver_stall_pct = 0;
            end
            2: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 63;
            end
            default: begin
               sender_idle_pct    = 28;
               receiver_stall_pct = 28;
            end
         endcase
         // long receiver hold-off while the sender keeps offering: the block
         // fills and has to stall req
         if (ph == PRESSURE_PH) hold_ask <= hold_ask + 1;

         for (int n = 0; n < PHASE_ITEMS; n++) begin
            send_item(random_item(), CHK_PREDICT, '0, live);
            if (live) live_items++;
         end
      end
      settle();

      $display("tb_top: %0d transactions taken, %0d of them table writes, %0d register writes",
               items_sent, writes_sent, settings_written);
      $display("tb_top: %0d mixer controls checked, %0d random transactions with effect, %0d phases",
               controls_checked, live_items, N_PHASES);
      if (errors == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule

### filelist.f
sv/mcm_pkg.sv
sv/mcm_ram.sv
sv/mcm_scaler.sv
sv/midi_cc_to_mixer_control_mapper_top.sv
tb/sv/tb_top.sv
